// ===== design/flow_controlled_byte_fifo_macros.svh =====
// Assertion macros used by the byte FIFO top-level design file.
`ifndef FLOW_CONTROLLED_BYTE_FIFO_MACROS_SVH
`define FLOW_CONTROLLED_BYTE_FIFO_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FCBF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FCBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fcbf_pkg.sv =====
package fcbf_pkg;

    // Default storage depth and reset value of the capacity register.
    localparam int DEPTH_DEF = 4096;
    localparam logic [12:0] CAP_RESET = 13'd4096;

    // Operation codes carried on the input tuser.
    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_PEEK   = 3'd2,
        OP_POP    = 3'd3,
        OP_END    = 3'd4,
        OP_STATUS = 3'd5
    } op_t;

    // One result beat, before packing onto the output bus.
    typedef struct packed {
        logic        data_valid;
        logic [7:0]  read_data;
        logic        accepted;
        logic        error;
        logic [12:0] stored_count;
        logic [12:0] free_space;
        logic [63:0] total_written;
        logic [63:0] total_read;
        logic        stream_ended;
        logic        at_eof;
    } res_t;

endpackage

// ===== design/fcbf_mem.sv =====
module fcbf_mem #(
    parameter int DEPTH = fcbf_pkg::DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);
    import fcbf_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/fcbf_ctrl.sv =====
module fcbf_ctrl #(
    parameter int DEPTH = fcbf_pkg::DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [12:0]              cfg_wr_data,
    input  logic                     accept,
    input  fcbf_pkg::op_t            op,
    input  logic [7:0]               wdata,
    input  logic [12:0]              amount,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [7:0]               mem_wdata,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    output fcbf_pkg::res_t           res_next
);
    import fcbf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 13) ? CW : 13;

    logic [12:0]   cap_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] held_reg, held_next;
    logic [63:0]   wtot_reg, wtot_next;
    logic [63:0]   rtot_reg, rtot_next;
    logic          ended_reg, ended_next;
    logic          err_reg, err_next;

    logic [XW-1:0] held_x, amt_x, cap_x, depth_x, eff_cap, off_x, held_nx_x, room_x;
    logic [AW:0]   sum, slot_w;
    logic [AW-1:0] slot;
    logic          valid, acc;

    // Capacity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Pointer, count, totals and flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            held_reg  <= '0;
            wtot_reg  <= '0;
            rtot_reg  <= '0;
            ended_reg <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            head_reg  <= head_next;
            held_reg  <= held_next;
            wtot_reg  <= wtot_next;
            rtot_reg  <= rtot_next;
            ended_reg <= ended_next;
            err_reg   <= err_next;
        end
    end

    // Widen everything to one compare width; the capacity is limited to the depth.
    assign held_x  = XW'(held_reg);
    assign amt_x   = XW'(amount);
    assign cap_x   = XW'(cap_reg);
    assign depth_x = XW'(DEPTH);
    assign eff_cap = (cap_x > depth_x) ? depth_x : cap_x;

    // Offset from the head: the count for a write, one for a read, else the amount.
    always_comb begin
        unique case (op)
            OP_WRITE: off_x = held_x;
            OP_READ:  off_x = XW'(1);
            default:  off_x = amt_x;
        endcase
    end

    // Circular slot: head plus offset stays below twice the depth when used.
    assign sum    = (AW + 1)'(head_reg) + (AW + 1)'(off_x);
    assign slot_w = (sum >= (AW + 1)'(DEPTH)) ? sum - (AW + 1)'(DEPTH) : sum;
    assign slot   = slot_w[AW-1:0];

    assign mem_waddr = slot;
    assign mem_wdata = wdata;
    assign mem_raddr = (op == OP_READ) ? head_reg : slot;

    // Operation decode and state update.
    always_comb begin
        head_next  = head_reg;
        held_next  = held_reg;
        wtot_next  = wtot_reg;
        rtot_next  = rtot_reg;
        ended_next = ended_reg;
        err_next   = err_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        valid      = 1'b0;
        acc        = 1'b0;
        if (accept) begin
            unique case (op)
                OP_WRITE: begin
                    if (held_x < eff_cap) begin
                        mem_we    = 1'b1;
                        held_next = held_reg + CW'(1);
                        wtot_next = wtot_reg + 64'd1;
                        acc       = 1'b1;
                    end
                end
                OP_READ: begin
                    if (held_reg != '0) begin
                        mem_re    = 1'b1;
                        valid     = 1'b1;
                        head_next = slot;
                        held_next = held_reg - CW'(1);
                        rtot_next = rtot_reg + 64'd1;
                        acc       = 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (amt_x < held_x) begin
                        mem_re = 1'b1;
                        valid  = 1'b1;
                    end
                end
                OP_POP: begin
                    if (amt_x > held_x) begin
                        err_next = 1'b1;
                    end else begin
                        head_next = slot;
                        held_next = held_reg - CW'(amt_x);
                        rtot_next = rtot_reg + 64'(amt_x);
                        acc       = 1'b1;
                    end
                end
                OP_END: begin
                    ended_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result fields reflect the state after this beat.
    assign held_nx_x = XW'(held_next);
    assign room_x    = (held_nx_x < eff_cap) ? eff_cap - held_nx_x : '0;

    always_comb begin
        res_next               = '0;
        res_next.data_valid    = valid;
        res_next.accepted      = acc;
        res_next.error         = err_next;
        res_next.stored_count  = held_nx_x[12:0];
        res_next.free_space    = room_x[12:0];
        res_next.total_written = wtot_next;
        res_next.total_read    = rtot_next;
        res_next.stream_ended  = ended_next;
        res_next.at_eof        = ended_next && (held_next == '0);
    end

endmodule

// ===== design/flow_controlled_byte_fifo.sv =====
// Bounded byte FIFO with flow control and an end-of-input mark.
// Input beats (s_*) carry an operation code on s_tuser and the write byte and
// the peek offset or pop amount on s_tdata. Each input beat yields exactly one
// output beat (m_*) reporting the byte read or peeked, whether the operation
// took effect, the sticky error flag, the count, free space, both 64-bit
// totals and the end-of-input and end-of-file flags.
// The capacity register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, which the block does not
// enforce. Values above DEPTH act as DEPTH. The output beat is registered and
// appears in the cycle after its input beat is accepted. One beat is taken per
// cycle while the output is not stalled: all bookkeeping happens in the accept
// cycle and the byte memory is either written or read in that cycle, its read
// data landing with the output register. The output register holds a beat
// until m_tready; s_tready stays high while that register is empty or being
// emptied, so a stalled receiver stalls the input after one beat.
// Reset (aresetn low, synchronous) empties the FIFO, clears the totals and
// flags and restores the capacity to 4096. The memory itself is not cleared.
module flow_controlled_byte_fifo #(
    parameter int DEPTH = fcbf_pkg::DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration: capacity register.
    input  logic          cfg_wr_en,
    input  logic [12:0]   cfg_wr_data,
    // Input stream.
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [23:0]   s_tdata,   // write_data[7:0], amount[20:8], zero[23:21]
    input  logic [2:0]    s_tuser,   // operation[2:0]
    // Result stream.
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [167:0]  m_tdata,   // read_data[7:0], accepted[8], error[9],
                                     // stored_count[22:10], free_space[35:23],
                                     // total_written[99:36], total_read[163:100],
                                     // stream_ended[164], at_eof[165], zero[167:166]
    output logic [0:0]    m_tuser    // data_valid[0]
);
    import fcbf_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          s_accept;
    op_t           op;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_q;
    res_t          res_next;
    res_t          m_res_reg;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    rd_byte;
    logic          eof_ok;

    // Input handshake.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);

    fcbf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (s_accept),
        .op          (op),
        .wdata       (s_tdata[7:0]),
        .amount      (s_tdata[20:8]),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .res_next    (res_next)
    );

    fcbf_mem #(.DEPTH(DEPTH)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    // Output valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register; the memory read data arrives alongside it.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_res_reg <= res_next;
        end
    end

    // The memory output holds until the next read, which only follows a handshake.
    assign rd_byte = m_res_reg.data_valid ? mem_q : 8'd0;

    // Pack the result beat.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.data_valid;
    assign m_tdata  = {2'b00,
                       m_res_reg.at_eof,
                       m_res_reg.stream_ended,
                       m_res_reg.total_read,
                       m_res_reg.total_written,
                       m_res_reg.free_space,
                       m_res_reg.stored_count,
                       m_res_reg.error,
                       m_res_reg.accepted,
                       rd_byte};

    // End of file is only legal when the input has ended and nothing is stored.
    assign eof_ok = m_res_reg.stream_ended && (m_res_reg.stored_count == 13'd0);

`include "flow_controlled_byte_fifo_macros.svh"

    // An accepted beat is presented on the next cycle with the computed result.
    `FCBF_ASSERT_NEXT(a_loaded, s_accept, m_tvalid && m_res_reg == $past(res_next), "beat lost")
    // The error flag never clears once reported.
    `FCBF_ASSERT_NEXT(a_err_sticky, m_tvalid && m_res_reg.error, m_res_reg.error, "error cleared")
    // End of file means the input has ended and nothing is stored.
    `FCBF_ASSERT_SAME(a_eof_ok, m_tvalid && m_res_reg.at_eof, eof_ok, "at_eof inconsistent")

endmodule
